// File: hdl/i2cbb_pkg.sv
package i2cbb_pkg;

   // Engine state, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_STOP  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   // Command codes on the mode field
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   // Phase code: [1] SCL, [0] SDA, [2] keep lines, [3] sample bit, [4] sample ack
   localparam int unsigned PH_KEEP_BIT   = 2;
   localparam int unsigned PH_SAMPLE_BIT = 3;
   localparam int unsigned PH_ACK_BIT    = 4;
   localparam logic [4:0]  PH_KEEP       = 5'b00100;
   localparam logic [4:0]  PH_SAMPLE     = 5'b01000;
   localparam logic [4:0]  PH_ACK        = 5'b10000;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'hffff;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] data_byte;
      logic       ack_extra_wait;
      logic       last_read;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
      logic       rejected;
   } rsp_type;

   // Number of line settings in a sequence
   function automatic logic [4:0] seq_length(input state_type kind, input logic extra);
      logic [4:0] len;
      begin
         unique case (kind)
            ST_START: len = 5'd4;
            ST_STOP:  len = 5'd3;
            ST_WRITE: len = 5'd28 + {4'b0, extra};
            ST_READ:  len = 5'd20;
            default:  len = 5'd0;
         endcase
         return len;
      end
   endfunction

   // Line setting and sample flags for phase p of the running sequence
   function automatic logic [4:0] phase_code(input state_type  kind,
                                             input logic [4:0] p,
                                             input logic [1:0] opt,
                                             input logic [7:0] sh);
      logic [4:0] code;
      logic [4:0] x;
      logic [8:0] prod;
      logic [2:0] b;
      logic [4:0] sub;
      logic       d;
      logic [4:0] q;
      begin
         x    = p - 5'd1;
         prod = {4'b0, x} * 9'd11;        // x/3 for x below 24
         b    = prod[7:5];
         sub  = x - {1'b0, b, 1'b0} - {2'b0, b};
         d    = sh[3'd7 - b];
         code = PH_KEEP;
         unique case (kind)
            ST_START: begin
               unique case (p[1:0])
                  2'd0: code = 5'd1;
                  2'd1: code = 5'd3;
                  2'd2: code = 5'd2;
                  default: code = 5'd0;
               endcase
            end
            ST_STOP: begin
               if (p == 5'd0) code = 5'd0;
               else if (p == 5'd1) code = 5'd2;
               else code = 5'd3;
            end
            ST_WRITE: begin
               q = p - 5'd25 - {4'b0, opt[0]};
               if (p == 5'd0) code = 5'd0;
               else if (p <= 5'd24) code = {3'b0, (sub == 5'd1), d};
               else if (opt[0] && p == 5'd25) code = PH_KEEP;
               else if (q == 5'd1) code = PH_ACK | 5'd3;
               else code = 5'd1;
            end
            ST_READ: begin
               q = p - 5'd17;
               if (p == 5'd0) code = 5'd1;
               else if (p <= 5'd16) code = (x[0] == 1'b0) ? (PH_SAMPLE | 5'd3) : 5'd1;
               else code = {3'b0, (q == 5'd1), opt[1]};
            end
            default: code = PH_KEEP;
         endcase
         return code;
      end
   endfunction

endpackage

// File: hdl/i2cbb_engine.sv
module i2cbb_engine
   import i2cbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     req,
   input  logic [15:0] phase_ticks,
   output rsp_type     rsp
);

   state_type   state_ff, state_in;
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] hold_ff, hold_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  read_ff, read_in;
   logic        ack_ff, ack_in;
   logic [1:0]  lines_ff, lines_in;
   logic [1:0]  opt_ff, opt_in;

   logic [15:0] limit;
   logic [15:0] hold_next;
   logic [4:0]  phase_next;
   logic [4:0]  code;
   logic        is_cmd;
   logic        rejected;
   logic        done;
   state_type   cmd_state;

   assign limit  = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
   assign is_cmd = (req.mode >= MODE_START) && (req.mode <= MODE_READ);

   always_comb begin
      unique case (req.mode)
         MODE_START: cmd_state = ST_START;
         MODE_STOP:  cmd_state = ST_STOP;
         MODE_WRITE: cmd_state = ST_WRITE;
         MODE_READ:  cmd_state = ST_READ;
         default:    cmd_state = ST_IDLE;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      shift_in   = shift_ff;
      read_in    = read_ff;
      ack_in     = ack_ff;
      lines_in   = lines_ff;
      opt_in     = opt_ff;
      rejected   = 1'b0;
      done       = 1'b0;
      code       = PH_KEEP;
      hold_next  = 16'd0;
      phase_next = 5'd0;

      if (step) begin
         // new command only when idle
         if (state_ff != ST_IDLE) begin
            rejected = is_cmd;
         end else if (is_cmd) begin
            state_in = cmd_state;
            phase_in = 5'd0;
            hold_in  = 16'd0;
            opt_in   = {req.last_read, req.ack_extra_wait};
            shift_in = (req.mode == MODE_WRITE) ? req.data_byte : 8'd0;
         end

         if (state_in != ST_IDLE) begin
            code = phase_code(state_in, phase_in, opt_in, shift_in);
            if (!code[PH_KEEP_BIT]) lines_in = code[1:0];
            hold_next = hold_in + 16'd1;
            if (hold_next >= limit) begin
               if (code[PH_SAMPLE_BIT]) shift_in = {shift_in[6:0], req.sda_in};
               if (code[PH_ACK_BIT]) ack_in = ~req.sda_in;
               hold_in    = 16'd0;
               phase_next = phase_in + 5'd1;
               if (phase_next >= seq_length(state_in, opt_in[0])) begin
                  if (state_in == ST_READ) read_in = shift_in;
                  state_in = ST_IDLE;
                  phase_in = 5'd0;
                  done     = 1'b1;
               end else begin
                  phase_in = phase_next;
               end
            end else begin
               hold_in = hold_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 5'd0;
         hold_ff  <= 16'd0;
         shift_ff <= 8'd0;
         read_ff  <= 8'd0;
         ack_ff   <= 1'b0;
         lines_ff <= 2'b11;
         opt_ff   <= 2'b00;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         shift_ff <= shift_in;
         read_ff  <= read_in;
         ack_ff   <= ack_in;
         lines_ff <= lines_in;
         opt_ff   <= opt_in;
      end
   end

   assign rsp.scl_out  = lines_in[1];
   assign rsp.sda_out  = lines_in[0];
   assign rsp.busy_res = (state_in != ST_IDLE);
   assign rsp.done_res = done;
   assign rsp.rx_byte  = read_in;
   assign rsp.ack_seen = ack_in;
   assign rsp.rejected = rejected;

endmodule

// File: hdl/i2c_bitbang_master.sv
// The result of an item appears on the rsp_ side in the cycle after the item is taken.
// Throughput: one item per cycle while the receiver takes results; the engine state updates
// in one pass each tick; the result register is refilled in the same cycle it is emptied.
// Reset (synchronous, active high): engine idle, both lines released high, counters and
// captured bytes cleared, phase_ticks back to 0xffff, result register empty.
module i2c_bitbang_master
   import i2cbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // tick items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_ack_extra_wait,
   input  logic        req_last_read,
   input  logic        req_sda_in,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_seen,
   output logic        rsp_rejected,
   // phase_ticks register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] phase_ticks_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_next;
   req_type     req;
   logic        accept;

   // a tick is taken whenever the result slot is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign req.mode           = req_mode;
   assign req.data_byte      = req_data_byte;
   assign req.ack_extra_wait = req_ack_extra_wait;
   assign req.last_read      = req_last_read;
   assign req.sda_in         = req_sda_in;

   // hold length per line setting, to be written only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   // bit engine: command sequencing, hold counter, shift and sample
   i2cbb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .req         (req),
      .phase_ticks (phase_ticks_ff),
      .rsp         (rsp_next)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_scl_out  = rsp_ff.scl_out;
   assign rsp_sda_out  = rsp_ff.sda_out;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_rx_byte  = rsp_ff.rx_byte;
   assign rsp_ack_seen = rsp_ff.ack_seen;
   assign rsp_rejected = rsp_ff.rejected;

endmodule

// File: tb/i2c_bitbang_master_chk.sv
`timescale 1ns / 1ps
module i2c_bitbang_master_chk
   import i2cbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_ack_extra_wait,
   input  logic        req_last_read,
   input  logic        req_sda_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_scl_out,
   input  logic        rsp_sda_out,
   input  logic        rsp_busy_res,
   input  logic        rsp_done_res,
   input  logic [7:0]  rsp_rx_byte,
   input  logic        rsp_ack_seen,
   input  logic        rsp_rejected,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatch_count,
   output int          outstanding_ticks
);

   // engine copy
   logic [15:0] hold_ticks_q;
   state_type   kind_q;
   logic [4:0]  phase_q;
   logic [15:0] hold_q;
   logic [7:0]  shift_q;
   logic [7:0]  rx_q;
   logic        ack_q;
   logic [1:0]  lines_q;   // {scl, sda}
   logic [1:0]  opt_q;     // {nack after read, extra wait}

   rsp_type line_outcomes[$];

   function automatic int unsigned settings_in(input state_type k, input logic extra);
      case (k)
         ST_START: return 4;
         ST_STOP:  return 3;
         ST_WRITE: return extra ? 29 : 28;
         ST_READ:  return 20;
         default:  return 0;
      endcase
   endfunction

   // line levels and sample flags of setting p
   function automatic logic [4:0] line_code(input state_type k, input logic [4:0] p,
                                            input logic [1:0] opt, input logic [7:0] sh);
      int unsigned n;
      int unsigned bit_no;
      logic [4:0]  c;
      n = p;
      c = PH_KEEP;
      case (k)
         ST_START: begin
            case (p[1:0])
               2'd0:    c = 5'd1;
               2'd1:    c = 5'd3;
               2'd2:    c = 5'd2;
               default: c = 5'd0;
            endcase
         end
         ST_STOP: c = (n == 0) ? 5'd0 : ((n == 1) ? 5'd2 : 5'd3);
         ST_WRITE: begin
            if (n == 0) begin
               c = 5'd0;
            end else if (n <= 24) begin
               bit_no = (n - 1) / 3;
               c = {3'b000, ((n - 1) % 3) == 1, sh[7 - bit_no]};
            end else if (opt[0] && n == 25) begin
               c = PH_KEEP;
            end else begin
               n = n - 25 - opt[0];
               c = (n == 1) ? (PH_ACK | 5'd3) : 5'd1;
            end
         end
         ST_READ: begin
            if (n == 0) begin
               c = 5'd1;
            end else if (n <= 16) begin
               c = (((n - 1) % 2) == 0) ? (PH_SAMPLE | 5'd3) : 5'd1;
            end else begin
               n = n - 17;
               c = {3'b000, n == 1, opt[1]};
            end
         end
         default: c = PH_KEEP;
      endcase
      return c;
   endfunction

   task automatic step_bit_engine(input req_type t);
      rsp_type     r;
      logic [4:0]  c;
      logic        is_cmd;
      int unsigned lim;
      r = '0;
      is_cmd = (t.mode >= MODE_START) && (t.mode <= MODE_READ);
      lim = (hold_ticks_q == 16'd0) ? 1 : hold_ticks_q;
      if (kind_q != ST_IDLE) begin
         r.rejected = is_cmd;
      end else if (is_cmd) begin
         case (t.mode)
            MODE_START: kind_q = ST_START;
            MODE_STOP:  kind_q = ST_STOP;
            MODE_WRITE: kind_q = ST_WRITE;
            default:    kind_q = ST_READ;
         endcase
         phase_q = '0;
         hold_q  = '0;
         opt_q   = {t.last_read, t.ack_extra_wait};
         shift_q = (t.mode == MODE_WRITE) ? t.data_byte : 8'h00;
      end
      if (kind_q != ST_IDLE) begin
         c = line_code(kind_q, phase_q, opt_q, shift_q);
         if (!c[PH_KEEP_BIT]) lines_q = c[1:0];
         hold_q = hold_q + 16'd1;
         if (hold_q >= lim) begin
            if (c[PH_SAMPLE_BIT]) shift_q = {shift_q[6:0], t.sda_in};
            if (c[PH_ACK_BIT]) ack_q = ~t.sda_in;
            hold_q  = '0;
            phase_q = phase_q + 5'd1;
            if (phase_q >= settings_in(kind_q, opt_q[0])) begin
               if (kind_q == ST_READ) rx_q = shift_q;
               kind_q     = ST_IDLE;
               phase_q    = '0;
               r.done_res = 1'b1;
            end
         end
      end
      r.scl_out  = lines_q[1];
      r.sda_out  = lines_q[0];
      r.busy_res = (kind_q != ST_IDLE);
      r.rx_byte  = rx_q;
      r.ack_seen = ack_q;
      line_outcomes.push_back(r);
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      req_type t;
      rsp_type w;
      if (reset) begin
         hold_ticks_q = PHASE_TICKS_RESET;
         kind_q  = ST_IDLE;
         phase_q = '0;
         hold_q  = '0;
         shift_q = '0;
         rx_q    = '0;
         ack_q   = 1'b0;
         lines_q = 2'b11;
         opt_q   = '0;
         line_outcomes.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) hold_ticks_q = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (line_outcomes.size() == 0) begin
               $display("%0t ns: result item with none expected, busy %0b done %0b",
                        $time, rsp_busy_res, rsp_done_res);
               mismatch_count++;
            end else begin
               w = line_outcomes.pop_front();
               check_field("scl_out",  w.scl_out,  rsp_scl_out);
               check_field("sda_out",  w.sda_out,  rsp_sda_out);
               check_field("busy_res", w.busy_res, rsp_busy_res);
               check_field("done_res", w.done_res, rsp_done_res);
               check_field("rx_byte",  w.rx_byte,  rsp_rx_byte);
               check_field("ack_seen", w.ack_seen, rsp_ack_seen);
               check_field("rejected", w.rejected, rsp_rejected);
            end
         end
         if (req_valid && req_ready) begin
            t.mode           = req_mode;
            t.data_byte      = req_data_byte;
            t.ack_extra_wait = req_ack_extra_wait;
            t.last_read      = req_last_read;
            t.sda_in         = req_sda_in;
            step_bit_engine(t);
         end
      end
      outstanding_ticks = line_outcomes.size();
   end

endmodule

// File: tb/tb_i2c_bitbang_master.sv
`timescale 1ns / 1ps
module tb_i2c_bitbang_master;
   import i2cbb_pkg::*;

   // how the SDA input is fed while a command runs
   localparam int SDA_LOW  = 0;
   localparam int SDA_HIGH = 1;
   localparam int SDA_RAND = 2;

   // modes with no meaning: plain ticks, never rejected
   localparam logic [2:0] MODE_RSVD_5 = 3'd5;
   localparam logic [2:0] MODE_RSVD_6 = 3'd6;
   localparam logic [2:0] MODE_RSVD_7 = 3'd7;

   localparam int MAX_IDLE           = 6;
   localparam int HOLD_OFF_CYCLES    = 80;   // long receiver stall
   localparam int HOLD_OFF_EVERY     = 500;  // ... once per this many result items
   localparam int RANDOM_PER_SETTING = 230;
   localparam int SETTLE_CYCLES      = 4;    // covers the result register delay, with margin

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = MODE_TICK;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_ack_extra_wait = 1'b0;
   logic        req_last_read = 1'b0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_seen;
   logic        rsp_rejected;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   int   mismatches;
   int   still_due;

   // bookkeeping of the stimulus side
   int   ticks_sent = 0;
   int   ticks_back = 0;
   int   done_seen  = 0;
   logic last_busy  = 1'b0;
   logic gaps_on    = 1'b1;

   // hold settings for the random part; zero behaves as one
   logic [15:0] hold_settings [5] = '{16'd0, 16'd2, 16'd3, 16'd7, 16'd1};

   i2c_bitbang_master u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_ack_extra_wait (req_ack_extra_wait),
      .req_last_read      (req_last_read),
      .req_sda_in         (req_sda_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_out        (rsp_scl_out),
      .rsp_sda_out        (rsp_sda_out),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_ack_seen       (rsp_ack_seen),
      .rsp_rejected       (rsp_rejected),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   i2c_bitbang_master_chk u_chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_ack_extra_wait (req_ack_extra_wait),
      .req_last_read      (req_last_read),
      .req_sda_in         (req_sda_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_out        (rsp_scl_out),
      .rsp_sda_out        (rsp_sda_out),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_ack_seen       (rsp_ack_seen),
      .rsp_rejected       (rsp_rejected),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatches),
      .outstanding_ticks  (still_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // safety net well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result items seen by the stimulus side: count, last busy flag, completions
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ticks_back <= ticks_back + 1;
         last_busy  <= rsp_busy_res;
         if (rsp_done_res) done_seen <= done_seen + 1;
      end
   end

   // receiver: random stall per item, and now and then a long hold-off so that
   // the result register stays full and the block has to stop taking ticks
   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % HOLD_OFF_EVERY == HOLD_OFF_EVERY / 2)
            stall = HOLD_OFF_CYCLES;
         else
            stall = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   function automatic logic pick_sda(input int how);
      case (how)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // mostly ticks; commands often enough that one lands soon after the engine
   // goes idle, the rest arriving while busy and being turned away
   function automatic logic [2:0] pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return MODE_WRITE;
      if (r < 17) return MODE_READ;
      if (r < 21) return MODE_START;
      if (r < 25) return MODE_STOP;
      if (r < 29) return 3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
      return MODE_TICK;
   endfunction

   // one item: optional gap, then hold valid until the block takes it
   task automatic offer(input logic [2:0] m, input logic [7:0] d, input logic x,
                        input logic l, input logic s);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= m;
      req_data_byte      <= d;
      req_ack_extra_wait <= x;
      req_last_read      <= l;
      req_sda_in         <= s;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic offer_tick(input int how);
      offer(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), pick_sda(how));
   endtask

   // stop offering and wait for every result item to come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (ticks_back != ticks_sent);
   endtask

   // tick until a result item reports the engine idle
   task automatic drain_engine();
      do begin
         offer_tick(SDA_RAND);
         settle();
      end while (last_busy);
   endtask

   // engine is idle and nothing is in flight here
   task automatic set_phase_ticks(input logic [15:0] v);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // issue a command from idle and stream ticks until its completion comes
   // back; poke adds a command and an unused mode while it runs
   task automatic run_command(input logic [2:0] m, input logic [7:0] d, input logic x,
                              input logic l, input int how, input logic poke);
      int target;
      target = done_seen + 1;
      offer(m, d, x, l, pick_sda(how));
      if (poke) begin
         offer(MODE_WRITE, 8'h3c, 1'b1, 1'b0, pick_sda(how));
         offer(MODE_RSVD_7, 8'hc3, 1'b0, 1'b1, pick_sda(how));
      end
      while (done_seen < target) offer_tick(how);
      settle();
   endtask

   initial begin : stimulus
      int s;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // longer holds, streamed back to back: a stop, then a read
      gaps_on <= 1'b0;
      set_phase_ticks(16'd30);
      run_command(MODE_STOP, 8'h00, 1'b0, 1'b0, SDA_HIGH, 1'b0);
      set_phase_ticks(16'd8);
      run_command(MODE_READ, 8'h00, 1'b0, 1'b1, SDA_RAND, 1'b1);

      // directed: each command, byte extremes, ACK and NACK both ways,
      // extra wait, rejection while busy, unused modes while idle
      gaps_on <= 1'b1;
      set_phase_ticks(16'd1);
      run_command(MODE_START, 8'h00, 1'b0, 1'b0, SDA_HIGH, 1'b1);
      run_command(MODE_WRITE, 8'h00, 1'b0, 1'b0, SDA_LOW,  1'b0);
      run_command(MODE_WRITE, 8'hff, 1'b1, 1'b1, SDA_HIGH, 1'b1);
      run_command(MODE_WRITE, 8'ha5, 1'b1, 1'b0, SDA_LOW,  1'b0);
      run_command(MODE_READ,  8'hff, 1'b0, 1'b0, SDA_HIGH, 1'b0);
      run_command(MODE_READ,  8'h00, 1'b1, 1'b1, SDA_LOW,  1'b0);
      run_command(MODE_READ,  8'h5a, 1'b0, 1'b0, SDA_RAND, 1'b1);
      run_command(MODE_STOP,  8'h00, 1'b0, 1'b0, SDA_RAND, 1'b1);
      offer(MODE_RSVD_5, 8'hff, 1'b1, 1'b1, 1'b0);
      offer(MODE_RSVD_6, 8'h00, 1'b0, 1'b0, 1'b1);
      offer(MODE_RSVD_7, 8'h81, 1'b1, 1'b0, 1'b0);
      settle();
      run_command(MODE_START, 8'h7e, 1'b1, 1'b1, SDA_LOW, 1'b0);

      // random ticks under several hold settings; bursts with and without gaps
      for (s = 0; s < 5; s++) begin
         set_phase_ticks(hold_settings[s]);
         for (k = 0; k < RANDOM_PER_SETTING; k++) begin
            if (k % 50 == 0) gaps_on <= ($urandom_range(0, 3) != 0);
            offer(pick_mode(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         drain_engine();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && still_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
